// ===== rtl/ucd_pkg.sv =====
// ucd_pkg: shared types and constants for the utf-8 code point decoder
// no dependencies; used by every module of the decoder
`timescale 1ns / 1ps

package ucd_pkg;

	localparam int CP_W     = 21;
	localparam int COUNT_W  = 13;
	localparam int BYTE_W   = 8;

	localparam logic [CP_W-1:0]    REPL_CP       = 21'h00FFFD;
	localparam logic [COUNT_W-1:0] MAX_CP_RESET  = 13'd256;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// one command covers every result caused by one byte:
	// n_repl replacement points first, then an optional tail result
	typedef struct packed {
		logic [1:0]         n_repl;
		logic               tail;
		logic               done;
		logic [CP_W-1:0]    cp;
		logic [COUNT_W-1:0] count;
	} cmd_t;

endpackage

// ===== rtl/ucd_front.sv =====
// ucd_front: accepts bytes, tracks the open sequence and the per-string count,
// and turns each byte into at most one command for the back end. depends on ucd_pkg
`timescale 1ns / 1ps

module ucd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [ucd_pkg::BYTE_W-1:0] byte_value,
	input  logic                       cfg_valid,
	input  logic [ucd_pkg::COUNT_W-1:0] cfg_data,
	input  logic                       q_full,
	output logic                       q_push,
	output ucd_pkg::cmd_t              q_cmd
);
	import ucd_pkg::*;

	logic [COUNT_W-1:0] max_q;
	logic [1:0]         needed_q, seen_q;
	logic [CP_W-1:0]    partial_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               lr_q;

	logic [1:0]         needed_d, seen_d;
	logic [CP_W-1:0]    partial_d;
	logic [COUNT_W-1:0] cnt_d;
	logic               lr_d;

	logic               accept;
	logic               avail_ok;
	logic [COUNT_W-1:0] avail;
	logic [1:0]         n_flush, e_flush;
	logic [COUNT_W-1:0] cnt_f, cnt_f1, cnt_c1;
	logic [CP_W-1:0]    pv;
	logic [1:0]         seen_p1;
	logic               is_cont;
	cmd_t               cmd;

	assign accept   = push && !q_full;
	assign avail_ok = cnt_q < max_q;
	assign avail    = max_q - cnt_q;
	assign n_flush  = (needed_q != 2'd0) ? seen_q + 2'd1 : 2'd0;
	// replacement points that still fit under the limit
	assign e_flush  = !avail_ok ? 2'd0 :
		((avail < {{(COUNT_W-2){1'b0}}, n_flush}) ? avail[1:0] : n_flush);
	assign cnt_f    = cnt_q + {{(COUNT_W-2){1'b0}}, e_flush};
	assign cnt_f1   = cnt_f + 1'b1;
	assign cnt_c1   = cnt_q + 1'b1;
	assign pv       = {partial_q[CP_W-7:0], byte_value[5:0]};
	assign seen_p1  = seen_q + 2'd1;
	assign is_cont  = byte_value[7:6] == 2'b10;

	always_comb begin
		needed_d  = needed_q;
		seen_d    = seen_q;
		partial_d = partial_q;
		cnt_d     = cnt_q;
		lr_d      = lr_q;
		cmd       = '0;
		if (byte_value == '0) begin
			cmd.n_repl = lr_q ? 2'd0 : e_flush;
			cmd.tail   = 1'b1;
			cmd.done   = 1'b1;
			cmd.count  = lr_q ? cnt_q : cnt_f;
			needed_d   = '0;
			seen_d     = '0;
			partial_d  = '0;
			cnt_d      = '0;
			lr_d       = 1'b0;
		end else if (lr_q || !avail_ok) begin
			lr_d      = 1'b1;
			needed_d  = '0;
			seen_d    = '0;
			partial_d = '0;
		end else if (needed_q != 2'd0 && is_cont) begin
			if (seen_p1 >= needed_q) begin
				cmd.tail  = 1'b1;
				cmd.cp    = pv;
				cnt_d     = cnt_c1;
				lr_d      = cnt_c1 >= max_q;
				needed_d  = '0;
				seen_d    = '0;
				partial_d = '0;
			end else begin
				partial_d = pv;
				seen_d    = seen_p1;
			end
		end else begin
			// flush any open sequence, then take the byte as a new lead, an ascii point or an invalid byte
			cmd.n_repl = e_flush;
			cnt_d      = cnt_f;
			needed_d   = '0;
			seen_d     = '0;
			partial_d  = '0;
			if (cnt_f >= max_q) begin
				lr_d = 1'b1;
			end else if (byte_value[7:5] == 3'b110) begin
				needed_d  = 2'd1;
				partial_d = {{(CP_W-5){1'b0}}, byte_value[4:0]};
			end else if (byte_value[7:4] == 4'b1110) begin
				needed_d  = 2'd2;
				partial_d = {{(CP_W-4){1'b0}}, byte_value[3:0]};
			end else if (byte_value[7:3] == 5'b11110) begin
				needed_d  = 2'd3;
				partial_d = {{(CP_W-3){1'b0}}, byte_value[2:0]};
			end else begin
				cmd.tail = 1'b1;
				cmd.cp   = !byte_value[7] ? {{(CP_W-BYTE_W){1'b0}}, byte_value} : REPL_CP;
				cnt_d    = cnt_f1;
				lr_d     = cnt_f1 >= max_q;
			end
		end
	end

	assign q_push = accept && (cmd.tail || cmd.n_repl != 2'd0);
	assign q_cmd  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q     <= MAX_CP_RESET;
			needed_q  <= '0;
			seen_q    <= '0;
			partial_q <= '0;
			cnt_q     <= '0;
			lr_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
			if (accept) begin
				needed_q  <= needed_d;
				seen_q    <= seen_d;
				partial_q <= partial_d;
				cnt_q     <= cnt_d;
				lr_q      <= lr_d;
			end
		end
	end

endmodule

// ===== rtl/ucd_queue.sv =====
// ucd_queue: small command queue between the front and the back end
// depends on ucd_pkg
`timescale 1ns / 1ps

module ucd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  ucd_pkg::cmd_t wr_cmd,
	input  logic          rd_en,
	output ucd_pkg::cmd_t rd_cmd,
	output logic          full,
	output logic          empty
);
	import ucd_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_wr, do_rd;

	assign full   = fill_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty  = fill_q == '0;
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ucd_back.sv =====
// ucd_back: expands queued commands into result items, one per cycle while
// the output register is empty or being popped. depends on ucd_pkg
`timescale 1ns / 1ps

module ucd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ucd_pkg::cmd_t               head,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  logic                        pop,
	output logic                        empty,
	output logic [ucd_pkg::CP_W-1:0]    code_point,
	output logic                        point_valid,
	output logic                        string_done,
	output logic [ucd_pkg::COUNT_W-1:0] point_count,
	output logic                        last
);
	import ucd_pkg::*;

	logic               ovalid_q;
	logic [1:0]         k_q;
	logic [CP_W-1:0]    cp_q;
	logic               pvalid_q, done_q, last_q;
	logic [COUNT_W-1:0] count_q;
	logic               load, in_repl, repl_end;
	logic [1:0]         k_p1;

	assign load     = !q_empty && (!ovalid_q || pop);
	assign in_repl  = k_q != head.n_repl;
	assign k_p1     = k_q + 2'd1;
	assign repl_end = (k_p1 == head.n_repl) && !head.tail;
	assign q_pop    = load && (!in_repl || repl_end);

	always_ff @(posedge clk) begin
		if (load) begin
			if (in_repl) begin
				cp_q     <= REPL_CP;
				pvalid_q <= 1'b1;
				done_q   <= 1'b0;
				count_q  <= '0;
				last_q   <= repl_end;
			end else begin
				cp_q     <= head.cp;
				pvalid_q <= !head.done;
				done_q   <= head.done;
				count_q  <= head.count;
				last_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			k_q      <= '0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				// step through the replacements, restart once the command retires
				k_q      <= q_pop ? 2'd0 : k_p1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign empty       = !ovalid_q;
	assign code_point  = cp_q;
	assign point_valid = pvalid_q;
	assign string_done = done_q;
	assign point_count = count_q;
	assign last        = last_q;

endmodule

// ===== rtl/utf8_codepoint_decoder.sv =====
// utf8_codepoint_decoder: top level, front end, command queue and back end
// depends on ucd_pkg, ucd_front, ucd_queue, ucd_back
`timescale 1ns / 1ps

// Decodes a zero-terminated UTF-8 byte stream into code points. Bytes enter
// through push/full, one per cycle; each byte is classified at once and leaves
// at most one command in a four-entry queue, so input is taken every cycle
// while the queue has room. While the output register is empty or being popped,
// the back end drains the queue at one result per cycle into that register, read
// through empty/pop; the command of a malformed sequence that gives several
// results (up to four) stays at the queue head until all are out. A zero
// byte flushes any open sequence as FFFD points and produces a done marker
// carrying the count. max_codepoints is written over cfg_valid/cfg_data
// (always ready) and should only change while the block is idle. There is
// no clearing pass after reset.

module utf8_codepoint_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [ucd_pkg::BYTE_W-1:0]  byte_value,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ucd_pkg::COUNT_W-1:0] cfg_data,
	output logic                        empty,
	input  logic                        pop,
	output logic [ucd_pkg::CP_W-1:0]    code_point,
	output logic                        point_valid,
	output logic                        string_done,
	output logic [ucd_pkg::COUNT_W-1:0] point_count,
	output logic                        last
);
	import ucd_pkg::*;

	logic q_push, q_pop, q_full, q_empty;
	cmd_t q_wr_cmd, q_head;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	ucd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.byte_value (byte_value),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_wr_cmd)
	);

	ucd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_cmd (q_wr_cmd),
		.rd_en  (q_pop),
		.rd_cmd (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	ucd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.code_point  (code_point),
		.point_valid (point_valid),
		.string_done (string_done),
		.point_count (point_count),
		.last        (last)
	);

`ifndef SYNTHESIS
	// the done marker always closes the results of its byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && string_done) |-> (last && !point_valid && code_point == '0))
		else $error("done marker malformed");

	a_point_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && point_valid) |-> (!string_done && point_count == '0))
		else $error("code point carries a count");

	// the back end never retires a command it has not presented
	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");
`endif

endmodule
